>>> design/hhc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhc_pkg: shared types and constants of the hashed hit counter
// Table geometry, status codes, slot word layout and sequencer states.
// ----------------------------------------------------------------------------
package hhc_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int TOP_K       = 10;
  localparam int HOME_SHIFT  = 3;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int OCC_W       = ADDR_W + 1;
  localparam int KC_W        = $clog2(TOP_K + 1);
  localparam int KI_W        = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam int CNT_W       = 32;
  localparam int KEY_W       = 16;

  localparam logic [1:0] STAT_RECORDED = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_EMPTY    = 2'd2;
  localparam logic [1:0] STAT_ENTRY    = 2'd3;

  localparam logic FUNC_RECORD = 1'b0;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] file;
    logic [KEY_W-1:0] line;
    logic [CNT_W-1:0] count;
  } slot_t;

  typedef struct packed {
    logic              clr;
    logic              ins;
    logic [CNT_W-1:0]  cnt;
    logic [ADDR_W-1:0] slot;
  } topk_cmd_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_REC_RD,
    S_REC_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SCAN_INS,
    S_OUT_SEL,
    S_OUT_RD,
    S_OUT_LAT,
    S_OUT
  } state_t;

endpackage

>>> design/hhc_topk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhc_topk: sorted top-K list with iterative insertion
// One comparator walks the list from the tail, one position per cycle.
// ----------------------------------------------------------------------------
module hhc_topk
  import hhc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  topk_cmd_t         cmd,
  input  logic [KI_W-1:0]   rd_idx,
  output logic              busy,
  output logic [KC_W-1:0]   used,
  output logic [CNT_W-1:0]  rd_cnt,
  output logic [ADDR_W-1:0] rd_slot
);

  logic [CNT_W-1:0]  top_cnt_r  [TOP_K];
  logic [ADDR_W-1:0] top_slot_r [TOP_K];
  logic              busy_r;
  logic [KC_W-1:0]   used_r;
  logic [KC_W-1:0]   pos_r;
  logic [CNT_W-1:0]  cand_cnt_r;
  logic [ADDR_W-1:0] cand_slot_r;
  logic [KI_W-1:0]   ridx;
  logic              cmp_gt;
  logic              pos_in;

  assign ridx    = busy_r ? KI_W'(pos_r - 1'b1) : rd_idx;
  assign cmp_gt  = (pos_r != '0) && (cand_cnt_r > top_cnt_r[ridx]);
  assign pos_in  = pos_r < KC_W'(TOP_K);
  assign busy    = busy_r;
  assign used    = used_r;
  assign rd_cnt  = top_cnt_r[ridx];
  assign rd_slot = top_slot_r[ridx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      used_r <= '0;
    end else begin
      if (cmd.clr) begin
        used_r <= '0;
      end
      if (cmd.ins) begin
        busy_r <= 1'b1;
      end else if (busy_r && !cmp_gt) begin
        busy_r <= 1'b0;
        if (used_r < KC_W'(TOP_K)) begin
          used_r <= used_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      cand_cnt_r  <= cmd.cnt;
      cand_slot_r <= cmd.slot;
      pos_r       <= used_r;
    end else if (busy_r) begin
      if (cmp_gt) begin
        if (pos_in) begin
          top_cnt_r[KI_W'(pos_r)]  <= top_cnt_r[ridx];
          top_slot_r[KI_W'(pos_r)] <= top_slot_r[ridx];
        end
        pos_r <= pos_r - 1'b1;
      end else if (pos_in) begin
        top_cnt_r[KI_W'(pos_r)]  <= cand_cnt_r;
        top_slot_r[KI_W'(pos_r)] <= cand_slot_r;
      end
    end
  end

endmodule

>>> design/hashed_hit_counter_top_k.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hashed_hit_counter_top_k: per-site hit counter with a top-K report
// Open-addressed slot table with linear probing and a top-K scan.
// ----------------------------------------------------------------------------
// Usage: an input transaction with in_func 0 records one hit of the site
// (in_site_file, in_site_line) and returns one result with the new count,
// or status "table full" once every slot is taken. An input transaction
// with in_func 1 scans all TABLE_DEPTH slots, returns up to TOP_K entries
// in descending count order (or one "report empty" result), and clears all
// counters while keeping the keys. out_last marks the final result.
// A record reads its home slot through the registered read of the
// single-port slot memory and probes the following slots in turn until it
// finds the site or a free slot. A report reads every slot, hands each
// non-zero count to the insertion comparator and waits until it is done;
// each entry then reads its slot's key before it is presented, and the
// next entry is fetched only after the previous one is taken. One input
// transaction is handled at a time; in_stall is high meanwhile.
// After reset a clearing pass writes every slot empty, with in_stall
// high. While out_stall is high the result holds and the block waits.
// ----------------------------------------------------------------------------
module hashed_hit_counter_top_k
  import hhc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_func,
  input  logic [15:0]      in_site_file,
  input  logic [15:0]      in_site_line,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_status,
  output logic [3:0]       out_rank,
  output logic [31:0]      out_hit_count,
  output logic [15:0]      out_entry_file,
  output logic [15:0]      out_entry_line,
  output logic             out_last
);

  slot_t             mem [TABLE_DEPTH];
  slot_t             rdata_r;
  logic              we;
  slot_t             wdata;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [KEY_W-1:0]  file_r, file_nxt;
  logic [KEY_W-1:0]  line_r, line_nxt;
  logic [KC_W-1:0]   oj_r, oj_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [3:0]        rank_r, rank_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [KEY_W-1:0]  efile_r, efile_nxt;
  logic [KEY_W-1:0]  eline_r, eline_nxt;
  logic              last_r, last_nxt;

  topk_cmd_t         cmd;
  logic              tk_busy;
  logic [KC_W-1:0]   tk_used;
  logic [CNT_W-1:0]  tk_cnt;
  logic [ADDR_W-1:0] tk_slot;
  logic              table_full;
  logic              scan_end;

  hhc_topk u_topk (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_idx  (KI_W'(oj_r)),
    .busy    (tk_busy),
    .used    (tk_used),
    .rd_cnt  (tk_cnt),
    .rd_slot (tk_slot)
  );

  assign table_full = occ_r == OCC_W'(TABLE_DEPTH);
  assign scan_end   = addr_r == ADDR_W'(TABLE_DEPTH - 1);
  assign in_stall   = state_r != S_IDLE;
  assign out_valid  = state_r == S_OUT;
  assign out_status     = status_r;
  assign out_rank       = rank_r;
  assign out_hit_count  = count_r;
  assign out_entry_file = efile_r;
  assign out_entry_line = eline_r;
  assign out_last       = last_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr_r] <= wdata;
    end
    rdata_r <= mem[addr_r];
  end

  always_comb begin
    state_nxt  = state_r;
    addr_nxt   = addr_r;
    occ_nxt    = occ_r;
    file_nxt   = file_r;
    line_nxt   = line_r;
    oj_nxt     = oj_r;
    status_nxt = status_r;
    rank_nxt   = rank_r;
    count_nxt  = count_r;
    efile_nxt  = efile_r;
    eline_nxt  = eline_r;
    last_nxt   = last_r;
    we         = 1'b0;
    wdata      = rdata_r;
    cmd        = '0;
    case (state_r)
      S_CLEAR: begin
        we       = 1'b1;
        wdata    = '0;
        addr_nxt = addr_r + 1'b1;
        if (scan_end) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          file_nxt = in_site_file;
          line_nxt = in_site_line;
          if (in_func != FUNC_RECORD) begin
            addr_nxt  = '0;
            cmd.clr   = 1'b1;
            state_nxt = S_SCAN_RD;
          end else if (table_full) begin
            status_nxt = STAT_FULL;
            rank_nxt   = '0;
            count_nxt  = '0;
            efile_nxt  = '0;
            eline_nxt  = '0;
            last_nxt   = 1'b1;
            state_nxt  = S_OUT;
          end else begin
            addr_nxt  = ADDR_W'({in_site_line, HOME_SHIFT'(0)});
            state_nxt = S_REC_RD;
          end
        end
      end
      S_REC_RD: begin
        state_nxt = S_REC_CHK;
      end
      S_REC_CHK: begin
        status_nxt = STAT_RECORDED;
        rank_nxt   = '0;
        efile_nxt  = file_r;
        eline_nxt  = line_r;
        last_nxt   = 1'b1;
        if (!rdata_r.valid) begin
          we          = 1'b1;
          wdata.valid = 1'b1;
          wdata.file  = file_r;
          wdata.line  = line_r;
          wdata.count = CNT_W'(1);
          occ_nxt     = occ_r + 1'b1;
          count_nxt   = CNT_W'(1);
          state_nxt   = S_OUT;
        end else if (rdata_r.file == file_r && rdata_r.line == line_r) begin
          we          = 1'b1;
          wdata.count = rdata_r.count + 1'b1;
          count_nxt   = rdata_r.count + 1'b1;
          state_nxt   = S_OUT;
        end else begin
          addr_nxt  = addr_r + 1'b1;
          state_nxt = S_REC_RD;
        end
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        we          = 1'b1;
        wdata.count = '0;
        if (rdata_r.count != '0) begin
          cmd.ins   = 1'b1;
          cmd.cnt   = rdata_r.count;
          cmd.slot  = addr_r;
          state_nxt = S_SCAN_INS;
        end else begin
          addr_nxt  = addr_r + 1'b1;
          oj_nxt    = '0;
          state_nxt = scan_end ? S_OUT_SEL : S_SCAN_RD;
        end
      end
      S_SCAN_INS: begin
        if (!tk_busy) begin
          addr_nxt  = addr_r + 1'b1;
          oj_nxt    = '0;
          state_nxt = scan_end ? S_OUT_SEL : S_SCAN_RD;
        end
      end
      S_OUT_SEL: begin
        if (tk_used == '0) begin
          status_nxt = STAT_EMPTY;
          rank_nxt   = '0;
          count_nxt  = '0;
          efile_nxt  = '0;
          eline_nxt  = '0;
          last_nxt   = 1'b1;
          state_nxt  = S_OUT;
        end else begin
          addr_nxt  = tk_slot;
          state_nxt = S_OUT_RD;
        end
      end
      S_OUT_RD: begin
        state_nxt = S_OUT_LAT;
      end
      S_OUT_LAT: begin
        status_nxt = STAT_ENTRY;
        rank_nxt   = 4'(oj_r);
        count_nxt  = tk_cnt;
        efile_nxt  = rdata_r.file;
        eline_nxt  = rdata_r.line;
        last_nxt   = oj_r == tk_used - 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          if (last_r) begin
            state_nxt = S_IDLE;
          end else begin
            oj_nxt    = oj_r + 1'b1;
            state_nxt = S_OUT_SEL;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      addr_r  <= '0;
      occ_r   <= '0;
      oj_r    <= '0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      occ_r   <= occ_nxt;
      oj_r    <= oj_nxt;
    end
  end

  always_ff @(posedge clk) begin
    file_r   <= file_nxt;
    line_r   <= line_nxt;
    status_r <= status_nxt;
    rank_r   <= rank_nxt;
    count_r  <= count_nxt;
    efile_r  <= efile_nxt;
    eline_r  <= eline_nxt;
    last_r   <= last_nxt;
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(TABLE_DEPTH))
    else $error("occupied slot count exceeds the table depth");

  a_out_topk_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !tk_busy)
    else $error("result presented while the top-K insertion is running");

  a_entry_rank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status_r == STAT_ENTRY) |-> (oj_r < tk_used))
    else $error("report entry beyond the filled top-K list");

  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r != $past(occ_r)) |-> ($past(state_r) == S_REC_CHK))
    else $error("occupied slot count changed outside a record probe");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the hashed hit counter with top-K report
// Records hits on random and colliding sites, requests reports and compares
// every result against an in-bench model of the slot table and top-K scan.
// ----------------------------------------------------------------------------
module tb;
  import hhc_pkg::*;

  typedef struct {
    logic        func;
    logic [15:0] file;
    logic [15:0] line;
  } site_req_t;

  typedef struct {
    logic [1:0]  status;
    logic [3:0]  rank;
    logic [31:0] cnt;
    logic [15:0] file;
    logic [15:0] line;
    logic        last;
  } hit_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_func = 1'b0;
  logic [15:0] in_site_file = '0;
  logic [15:0] in_site_line = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [3:0]  out_rank;
  logic [31:0] out_hit_count;
  logic [15:0] out_entry_file;
  logic [15:0] out_entry_line;
  logic        out_last;

  site_req_t pending_reqs[$];
  hit_res_t  expected_results[$];

  logic        tbl_valid[TABLE_DEPTH];
  logic [15:0] tbl_file[TABLE_DEPTH];
  logic [15:0] tbl_line[TABLE_DEPTH];
  logic [31:0] tbl_count[TABLE_DEPTH];
  int          tbl_used;

  int  mismatches = 0;
  int  results_seen = 0;
  int  reports_sent = 0;
  int  full_seen = 0;
  int  burst_cycles = 0;
  bit  stim_done = 1'b0;
  bit  in_taken = 1'b0;

  hashed_hit_counter_top_k dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic push_result(input logic [1:0] st, input int rk, input logic [31:0] c,
                             input logic [15:0] f, input logic [15:0] l, input logic lst);
    hit_res_t r;
    r.status = st;
    r.rank = rk[3:0];
    r.cnt = c;
    r.file = f;
    r.line = l;
    r.last = lst;
    expected_results.push_back(r);
  endtask

  task automatic predict_hits(input site_req_t q);
    int idx;
    int top_slot[TOP_K];
    logic [31:0] top_cnt[TOP_K];
    int taken;
    int j;
    if (q.func == FUNC_RECORD) begin
      if (tbl_used >= TABLE_DEPTH) begin
        push_result(STAT_FULL, 0, 0, 0, 0, 1'b1);
        return;
      end
      idx = (int'(q.line) << HOME_SHIFT) % TABLE_DEPTH;
      for (int s = 0; s < TABLE_DEPTH; s++) begin
        if (!tbl_valid[idx] || (tbl_file[idx] == q.file && tbl_line[idx] == q.line)) break;
        idx = (idx + 1) % TABLE_DEPTH;
      end
      if (!tbl_valid[idx]) begin
        tbl_valid[idx] = 1'b1;
        tbl_file[idx] = q.file;
        tbl_line[idx] = q.line;
        tbl_used++;
      end
      tbl_count[idx] = tbl_count[idx] + 32'd1;
      push_result(STAT_RECORDED, 0, tbl_count[idx], q.file, q.line, 1'b1);
    end else begin
      taken = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (tbl_count[i] != 0 && (taken < TOP_K || tbl_count[i] > top_cnt[TOP_K-1])) begin
          j = (taken < TOP_K) ? taken - 1 : TOP_K - 2;
          while (j >= 0 && tbl_count[i] > top_cnt[j]) begin
            top_cnt[j+1] = top_cnt[j];
            top_slot[j+1] = top_slot[j];
            j--;
          end
          top_cnt[j+1] = tbl_count[i];
          top_slot[j+1] = i;
          if (taken < TOP_K) taken++;
        end
        tbl_count[i] = 0;
      end
      if (taken == 0) push_result(STAT_EMPTY, 0, 0, 0, 0, 1'b1);
      for (int k = 0; k < taken; k++)
        push_result(STAT_ENTRY, k, top_cnt[k], tbl_file[top_slot[k]],
                    tbl_line[top_slot[k]], k == taken - 1);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  task automatic add_req(input logic fn, input logic [15:0] f, input logic [15:0] l);
    site_req_t q;
    q.func = fn;
    q.file = f;
    q.line = l;
    pending_reqs.push_back(q);
  endtask

  // Driver: one transaction presented at a time, held while stalled.
  always @(negedge clk) begin
    if (burst_cycles > 0) burst_cycles <= burst_cycles - 1;
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        in_taken = 1'b0;
        if (pending_reqs.size() > 0 && (burst_cycles > 0 || $urandom_range(99) >= 20)) begin
          in_valid <= 1'b1;
          in_func <= pending_reqs[0].func;
          in_site_file <= pending_reqs[0].file;
          in_site_line <= pending_reqs[0].line;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= (burst_cycles == 0) && ($urandom_range(99) < 20);
    end
  end

  // Monitor: the predictor runs when the transaction is sampled accepted.
  always @(posedge clk) begin
    hit_res_t e;
    if (rst_n && in_valid && !in_stall) begin
      predict_hits(pending_reqs.pop_front());
      if (in_func) reports_sent++;
      in_taken = 1'b1;
    end
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_status == STAT_FULL) full_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result status", 32'(out_status), 32'(0));
      end else begin
        e = expected_results.pop_front();
        if (out_status !== e.status)
          report_mismatch("status", 32'(out_status), 32'(e.status));
        if (out_rank !== e.rank) report_mismatch("rank", 32'(out_rank), 32'(e.rank));
        if (out_hit_count !== e.cnt) report_mismatch("hit_count", out_hit_count, e.cnt);
        if (out_entry_file !== e.file)
          report_mismatch("entry_file", 32'(out_entry_file), 32'(e.file));
        if (out_entry_line !== e.line)
          report_mismatch("entry_line", 32'(out_entry_line), 32'(e.line));
        if (out_last !== e.last) report_mismatch("last", 32'(out_last), 32'(e.last));
      end
    end
  end

  initial begin
    logic [15:0] f;
    logic [15:0] l;
    logic [15:0] hot_lines[8];
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_file[i] = '0;
      tbl_line[i] = '0;
      tbl_count[i] = '0;
    end
    tbl_used = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty report, field extremes, collisions on shared home slots.
    add_req(1'b1, 16'h0000, 16'h0000);
    add_req(1'b0, 16'h0000, 16'h0000);
    add_req(1'b0, 16'hFFFF, 16'hFFFF);
    add_req(1'b0, 16'hFFFF, 16'h0000);
    add_req(1'b0, 16'h0000, 16'h0080);
    add_req(1'b0, 16'h0000, 16'h0000);
    add_req(1'b0, 16'h1234, 16'h007F);
    add_req(1'b0, 16'hA5A5, 16'h5A5A);
    add_req(1'b0, 16'h5A5A, 16'hA5A5);
    add_req(1'b0, 16'hFFFF, 16'hFFFF);
    add_req(1'b1, 16'hFFFF, 16'hFFFF);
    add_req(1'b1, 16'h0000, 16'h0000);
    for (int i = 0; i < 12; i++) add_req(1'b0, i[15:0], 16'h0000 + 16'(i % 3));
    add_req(1'b1, 16'h0000, 16'h0000);

    // Random: a small set of hot sites with skewed hit counts, plus noise and occasional reports.
    for (int i = 0; i < 8; i++) hot_lines[i] = 16'($urandom);
    for (int i = 0; i < 215; i++) begin
      if ($urandom_range(99) < 8) begin
        add_req(1'b1, 16'($urandom), 16'($urandom));
      end else if ($urandom_range(99) < 60) begin
        l = hot_lines[$urandom_range(7) % ($urandom_range(7) + 1)];
        add_req(1'b0, l ^ 16'h5555, l);
      end else begin
        f = 16'($urandom);
        l = 16'($urandom);
        add_req(1'b0, f, l);
      end
    end
    add_req(1'b1, 16'h0000, 16'h0000);

    // Closing records on a cleared table, then a final report.
    add_req(1'b0, 16'h0000, 16'h0000);
    add_req(1'b0, 16'($urandom), 16'($urandom));
    add_req(1'b1, 16'h0000, 16'h0000);

    burst_cycles <= 600;
    wait (pending_reqs.size() == 0 && !in_valid);
    stim_done = 1'b1;
    wait (expected_results.size() == 0);
    repeat (50) @(posedge clk);
    $display("Covered %0d results, %0d reports and %0d refused records on a full table.",
             results_seen, reports_sent, full_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("Timed out with %0d results outstanding.", expected_results.size());
    $display("status: fail");
    $finish;
  end

endmodule

>>> sim.f
design/hhc_pkg.sv
design/hhc_topk.sv
design/hashed_hit_counter_top_k.sv
tb/sv/tb.sv
